>>> src/lfu_pkg.sv
// Package for the LFU cache table: payload types, entry layout and constants.
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int CFG_W            = 5;
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               op;
      logic signed [31:0] lookup_key;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] value;
      logic [31:0] use_count;
      logic [63:0] last_touch;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // sequencer -> scan unit
   typedef struct packed {
      logic clear;
      logic load;
   } scan_ctrl_type;

   // scan unit -> sequencer
   typedef struct packed {
      logic        found;
      logic [31:0] found_value;
      logic [31:0] found_count;
      logic        victim_valid;
      logic [31:0] victim_key;
   } scan_stat_type;

endpackage

`default_nettype wire

>>> src/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/lfu_scan.sv
// Scan unit: one entry per cycle, tracks the key match and the LFU/LRU victim.
`timescale 1ns / 1ps
`default_nettype none

module lfu_scan #(
   parameter int IDX_W = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lfu_pkg::scan_ctrl_type ctrl,
   input  wire logic [31:0]            key,
   input  wire logic [IDX_W-1:0]       slot,
   input  wire lfu_pkg::entry_type     rd_data,
   output lfu_pkg::scan_stat_type      stat,
   output logic [IDX_W-1:0]            found_slot,
   output logic [IDX_W-1:0]            victim_slot
);

   import lfu_pkg::*;

   logic             found_ff,     found_in;
   logic [IDX_W-1:0] fslot_ff,     fslot_in;
   logic [31:0]      fvalue_ff,    fvalue_in;
   logic [31:0]      fcount_ff,    fcount_in;
   logic             vvalid_ff,    vvalid_in;
   logic [IDX_W-1:0] vslot_ff,     vslot_in;
   logic [31:0]      vkey_ff,      vkey_in;
   logic [31:0]      vcount_ff,    vcount_in;
   logic [63:0]      vstamp_ff,    vstamp_in;
   logic             better;

   // lower count wins, then older stamp; strict compare keeps the lowest slot on ties
   assign better = (rd_data.use_count < vcount_ff) ||
                   ((rd_data.use_count == vcount_ff) && (rd_data.last_touch < vstamp_ff));

   always_comb begin
      found_in  = found_ff;
      fslot_in  = fslot_ff;
      fvalue_in = fvalue_ff;
      fcount_in = fcount_ff;
      vvalid_in = vvalid_ff;
      vslot_in  = vslot_ff;
      vkey_in   = vkey_ff;
      vcount_in = vcount_ff;
      vstamp_in = vstamp_ff;
      if (ctrl.clear) begin
         found_in  = 1'b0;
         vvalid_in = 1'b0;
      end else if (ctrl.load) begin
         if (!found_ff && (rd_data.key == key)) begin
            found_in  = 1'b1;
            fslot_in  = slot;
            fvalue_in = rd_data.value;
            fcount_in = rd_data.use_count;
         end
         if (!vvalid_ff || better) begin
            vvalid_in = 1'b1;
            vslot_in  = slot;
            vkey_in   = rd_data.key;
            vcount_in = rd_data.use_count;
            vstamp_in = rd_data.last_touch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff  <= 1'b0;
         vvalid_ff <= 1'b0;
      end else begin
         found_ff  <= found_in;
         vvalid_ff <= vvalid_in;
      end
      fslot_ff  <= fslot_in;
      fvalue_ff <= fvalue_in;
      fcount_ff <= fcount_in;
      vslot_ff  <= vslot_in;
      vkey_ff   <= vkey_in;
      vcount_ff <= vcount_in;
      vstamp_ff <= vstamp_in;
   end

   assign stat.found        = found_ff;
   assign stat.found_value  = fvalue_ff;
   assign stat.found_count  = fcount_ff;
   assign stat.victim_valid = vvalid_ff;
   assign stat.victim_key   = vkey_ff;
   assign found_slot        = fslot_ff;
   assign victim_slot       = vslot_ff;

endmodule

`default_nettype wire

>>> src/lfu_cache_table_top.sv
// Top level of the LFU cache table: sequencer, entry RAM, scan unit, output register.
//
// Key-value store with least-frequently-used replacement, oldest access stamp
// breaking ties among equal use counts.
// - req channel (valid/ready): op (get/put), lookup_key, write_value. One
//   transfer per item; req_ready is high only while the sequencer is idle.
// - rsp channel (valid/ready): exactly one transfer per item with hit,
//   read_value, evicted, evicted_key.
// - csr port: csr_wr_en/csr_wr_data write active_capacity (reset 16), which
//   saturates at CAPACITY. Write it only while no item is in flight.
// Scan: the sequencer reads the occupied entries (at most CAPACITY) from the
// RAM one per cycle (single read port). The next item is taken in the cycle
// after the result is loaded into the output register, so a new request is
// not accepted before the sequencer has finished with the last one.
// Entries fill slots in order and are never invalidated, so a fill count
// stands in for valid bits; reset zeroes it and the access clock, no clearing
// pass is needed.
// If rsp_ready is low, the result holds in the output register and a new item
// may still be accepted and scanned; it waits for the register before update.
`timescale 1ns / 1ps
`default_nettype none

module lfu_cache_table_top #(
   parameter int CAPACITY = lfu_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire lfu_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output lfu_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [lfu_pkg::CFG_W-1:0] csr_wr_data
);

   import lfu_pkg::*;

   localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int CmpW = (CntW > CFG_W) ? CntW : CFG_W;
   localparam logic [CmpW-1:0] CapMax = CmpW'(CAPACITY);
   localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [CFG_W-1:0] cfg_ff;
   req_type         req_ff;
   logic [CntW-1:0] used_ff, used_in;
   logic [CntW-1:0] issue_ff, issue_in;
   logic            pend_ff, pend_in;
   logic [IdxW-1:0] slot_ff;
   logic [63:0]     clock_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            req_fire;
   logic            issue;
   logic            decide_go;
   logic [CmpW-1:0] cap_eff;
   logic            get_hit, put_ok, put_hit, put_evict, put_fill;
   logic            ram_we;
   logic [IdxW-1:0] ram_waddr;
   entry_type       ram_wdata;
   entry_type       ram_rdata;
   logic [ENTRY_W-1:0] ram_rbits;
   logic [31:0]     count_inc;

   scan_ctrl_type   scan_ctrl;
   scan_stat_type   scan_stat;
   logic [IdxW-1:0] found_slot;
   logic [IdxW-1:0] victim_slot;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign issue     = (state_ff == ST_SCAN) && (issue_ff != used_ff);
   // result register must be free (or draining) before the update commits
   assign decide_go = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ready);

   assign cap_eff = (CmpW'(cfg_ff) > CapMax) ? CapMax : CmpW'(cfg_ff);

   // ---- item decision, from the finished scan ----
   assign get_hit   = (req_ff.op == OP_GET) && scan_stat.found;
   assign put_ok    = (req_ff.op == OP_PUT) && (cap_eff != '0);
   assign put_hit   = put_ok && scan_stat.found;
   assign put_evict = put_ok && !scan_stat.found && (CmpW'(used_ff) >= cap_eff) &&
                      scan_stat.victim_valid;
   assign put_fill  = put_ok && !scan_stat.found && !put_evict && (used_ff != FullCnt);

   assign count_inc = (scan_stat.found_count == COUNT_MAX) ? COUNT_MAX :
                      scan_stat.found_count + 32'd1;

   assign ram_we = decide_go && (get_hit || put_hit || put_evict || put_fill);

   always_comb begin
      if (scan_stat.found) begin
         ram_waddr = found_slot;
      end else if (put_evict) begin
         ram_waddr = victim_slot;
      end else begin
         ram_waddr = used_ff[IdxW-1:0];
      end
      ram_wdata.key        = req_ff.lookup_key;
      ram_wdata.value      = get_hit ? scan_stat.found_value : req_ff.write_value;
      ram_wdata.use_count  = scan_stat.found ? count_inc : 32'd1;
      ram_wdata.last_touch = clock_ff;
   end

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      pend_in  = issue;
      used_in  = used_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
               issue_in = '0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               issue_in = issue_ff + CntW'(1);
            end else if (!pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (decide_go) begin
               state_in = ST_IDLE;
               if (put_fill) begin
                  used_in = used_ff + CntW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign scan_ctrl.clear = req_fire;
   assign scan_ctrl.load  = pend_ff;

   // ---- output register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (decide_go) begin
         rsp_valid_in       = 1'b1;
         rsp_in.hit         = get_hit || put_hit;
         rsp_in.read_value  = get_hit ? scan_stat.found_value : '0;
         rsp_in.evicted     = put_evict;
         rsp_in.evicted_key = put_evict ? scan_stat.victim_key : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         used_ff      <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (ram_we) begin
            clock_ff <= clock_ff + 64'd1;
         end
      end
      if (req_fire) begin
         req_ff <= req_data;
      end
      slot_ff <= issue_ff[IdxW-1:0];
      rsp_ff  <= rsp_in;
   end

   lfu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY),
      .AW    (IdxW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (issue_ff[IdxW-1:0]),
      .rd_data (ram_rbits)
   );

   assign ram_rdata = entry_type'(ram_rbits);

   lfu_scan #(
      .IDX_W (IdxW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .key         (req_ff.lookup_key),
      .slot        (slot_ff),
      .rd_data     (ram_rdata),
      .stat        (scan_stat),
      .found_slot  (found_slot),
      .victim_slot (victim_slot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- assertions ----
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FullCnt)
      else $error("fill count beyond capacity");

   a_stamp_step: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (clock_ff == $past(clock_ff) + 64'd1))
      else $error("access clock did not advance on entry update");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.evicted |-> !rsp_ff.hit)
      else $error("eviction reported on a hit");

   a_scan_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN) && (issue_ff == '0))
      else $error("accepted item did not start a scan");

endmodule

`default_nettype wire
